// File: hdl/swmd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmd_pkg
// Shared types and constants for the stack with middle delete.
// ----------------------------------------------------------------------------
package swmd_pkg;

	localparam int FIELD_W = 32;
	localparam int COUNT_W = 7;

	typedef enum logic [1:0] {
		REQ_QUERY  = 2'd0,
		REQ_PUSH   = 2'd1,
		REQ_POP    = 2'd2,
		REQ_DELMID = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		req_kind_t                   req_type;
		logic signed [FIELD_W-1:0]   push_value;
	} req_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0]   top_value;
		logic signed [FIELD_W-1:0]   middle_value;
		logic [COUNT_W-1:0]          entry_count;
		logic                        is_empty;
		status_t                     status;
	} rsp_t;

	// per-cycle move of a whole chain
	typedef enum logic [1:0] {
		OP_HOLD      = 2'd0,
		OP_SHIFT_IN  = 2'd1,	// insert at cell 0, everything moves up
		OP_SHIFT_OUT = 2'd2	// drop cell 0, everything moves down
	} chain_op_t;

	typedef struct packed {
		chain_op_t op;
		logic      wr_en;	// indexed write, applied after the move
	} chain_ctl_t;

endpackage

// File: hdl/swmd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmd_cell
// One storage cell of a chain: holds a word, takes it from a neighbor on a
// shift, or takes the broadcast word when the write index names this cell.
// ----------------------------------------------------------------------------
module swmd_cell #(
	parameter int DW  = 32,
	parameter int IW  = 1,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  swmd_pkg::chain_ctl_t ctl,
	input  logic [DW-1:0]        lower_q,
	input  logic [DW-1:0]        upper_q,
	input  logic [IW-1:0]        wr_idx,
	input  logic [DW-1:0]        wr_data,
	output logic [DW-1:0]        q,
	output logic [DW-1:0]        d
);
	import swmd_pkg::*;

	logic [DW-1:0] data_q;

	always_comb begin
		unique case (ctl.op)
			OP_HOLD:      d = data_q;
			OP_SHIFT_IN:  d = lower_q;
			OP_SHIFT_OUT: d = upper_q;
			default:      d = data_q;
		endcase
		if (ctl.wr_en && (wr_idx == IW'(IDX))) begin
			d = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= d;
	end

	assign q = data_q;

endmodule

// File: hdl/swmd_chain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmd_chain
// A row of cells. Cell 0 is the open end; cells past the occupied length
// hold don't-care data.
// ----------------------------------------------------------------------------
module swmd_chain #(
	parameter int DW = 32,
	parameter int N  = 32,
	parameter int IW = 5
) (
	input  logic                 clk,
	input  swmd_pkg::chain_ctl_t ctl,
	input  logic [DW-1:0]        head,
	input  logic [IW-1:0]        wr_idx,
	input  logic [DW-1:0]        wr_data,
	output logic [DW-1:0]        head_q,
	output logic [DW-1:0]        head_d
);
	import swmd_pkg::*;

	logic [DW-1:0] cell_q [N];
	logic [DW-1:0] cell_d [N];

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic [DW-1:0] lower;
		logic [DW-1:0] upper;

		if (i == 0) begin : g_first
			assign lower = head;
		end else begin : g_mid
			assign lower = cell_q[i-1];
		end

		if (i == N-1) begin : g_last
			assign upper = cell_q[i];
		end else begin : g_inner
			assign upper = cell_q[i+1];
		end

		swmd_cell #(
			.DW  (DW),
			.IW  (IW),
			.IDX (i)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.lower_q (lower),
			.upper_q (upper),
			.wr_idx  (wr_idx),
			.wr_data (wr_data),
			.q       (cell_q[i]),
			.d       (cell_d[i])
		);
	end

	assign head_q = cell_q[0];
	assign head_d = cell_d[0];

endmodule

// File: hdl/stack_with_middle_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_middle_delete
// Bounded stack of signed words with O(1) access to, and removal of, its
// middle entry.
// ----------------------------------------------------------------------------
// One request per clock: every request is applied to the cell chains at the
// edge that accepts it and its result sits in an output register in the cycle
// after acceptance, so a stream of requests runs at one per cycle as long as the
// result side keeps up; req_stall rises only while a held result is stalled.
// The entries live in three chains of cells. The lower chain holds the bottom
// half up to and including the middle, with the middle in cell 0. The upper
// half is kept twice, once with its top in cell 0 and once with its bottom in
// cell 0, so top, middle and the word next above the middle are always at a
// fixed cell and a request only moves words between neighbors or writes one
// cell picked by the fill level. Unwritten cells are never shown.
// ----------------------------------------------------------------------------
module stack_with_middle_delete #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  swmd_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output swmd_pkg::rsp_t rsp
);
	import swmd_pkg::*;

	localparam int LD  = (DEPTH + 1) / 2;
	localparam int UD  = DEPTH / 2;
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int LIW = (LD > 1) ? $clog2(LD) : 1;
	localparam int UIW = (UD > 1) ? $clog2(UD) : 1;
	localparam int EW  = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

	logic                         acc;
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                count_nxt;
	logic [CW-1:0]                half;
	status_t                      status_nxt;
	logic                         full;
	logic                         n_odd;
	logic                         n_zero;

	logic signed [EW-1:0]         push_ext;
	logic [DATA_WIDTH-1:0]        push_word;

	chain_ctl_t                   l_ctl, u1_ctl, u2_ctl;
	logic [DATA_WIDTH-1:0]        l_head, u1_head, u2_head;
	logic [LIW-1:0]               l_widx;
	logic [UIW-1:0]               u1_widx, u2_widx;
	logic [UIW-1:0]               u_at, u_below;
	logic [DATA_WIDTH-1:0]        l_wdata, u1_wdata, u2_wdata;
	logic [DATA_WIDTH-1:0]        l_q0, l_d0, u1_d0, u2_q0;

	logic signed [DATA_WIDTH-1:0] mid_word, top_word;
	logic signed [EW-1:0]         mid_ext, top_ext;
	rsp_t                         rsp_nxt;
	rsp_t                         rsp_q;
	logic                         rsp_valid_q;

	assign req_stall = rsp_valid_q & rsp_stall;
	assign acc       = req_valid & ~req_stall;

	assign push_ext  = EW'(req.push_value);
	assign push_word = push_ext[DATA_WIDTH-1:0];

	assign n_zero  = (count_q == '0);
	assign n_odd   = count_q[0];
	assign full    = (count_q == CW'(DEPTH));
	assign half    = count_q >> 1;
	assign u_at    = UIW'(half);
	assign u_below = UIW'(half - CW'(1));

	// n = entries held. Lower chain holds (n+1)/2 words, upper n/2.
	always_comb begin
		count_nxt  = count_q;
		status_nxt = ST_OK;
		l_ctl      = '{op: OP_HOLD, wr_en: 1'b0};
		u1_ctl     = '{op: OP_HOLD, wr_en: 1'b0};
		u2_ctl     = '{op: OP_HOLD, wr_en: 1'b0};
		l_head     = push_word;
		u1_head    = push_word;
		u2_head    = l_q0;
		l_widx     = '0;
		u1_widx    = u_below;
		u2_widx    = u_at;
		l_wdata    = u2_q0;
		u1_wdata   = l_q0;
		u2_wdata   = push_word;
		if (acc) begin
			unique case (req.req_type)
				REQ_QUERY: begin
					status_nxt = ST_OK;
				end
				REQ_PUSH: begin
					if (full) begin
						status_nxt = ST_FULL;
					end else begin
						count_nxt = count_q + CW'(1);
						if (n_zero) begin
							l_ctl.op = OP_SHIFT_IN;
						end else if (!n_odd) begin
							// upper bottom drops into the lower half
							l_ctl.op     = OP_SHIFT_IN;
							l_head       = u2_q0;
							u1_ctl.op    = OP_SHIFT_IN;
							u2_ctl.op    = OP_SHIFT_OUT;
							u2_ctl.wr_en = 1'b1;
							u2_widx      = u_below;
						end else begin
							u1_ctl.op    = OP_SHIFT_IN;
							u2_ctl.wr_en = 1'b1;
							u2_widx      = u_at;
						end
					end
				end
				REQ_POP: begin
					if (n_zero) begin
						status_nxt = ST_EMPTY;
					end else begin
						count_nxt = count_q - CW'(1);
						if (count_q == CW'(1)) begin
							l_ctl.op = OP_SHIFT_OUT;
						end else if (n_odd) begin
							// old middle climbs to the bottom of the upper half
							l_ctl.op     = OP_SHIFT_OUT;
							u1_ctl.op    = OP_SHIFT_OUT;
							u1_ctl.wr_en = 1'b1;
							u1_widx      = u_below;
							u2_ctl.op    = OP_SHIFT_IN;
						end else begin
							u1_ctl.op = OP_SHIFT_OUT;
						end
					end
				end
				REQ_DELMID: begin
					if (n_zero) begin
						status_nxt = ST_EMPTY;
					end else begin
						count_nxt = count_q - CW'(1);
						if (n_odd) begin
							l_ctl.op = OP_SHIFT_OUT;
						end else begin
							// replace the middle with the word above it
							l_ctl.wr_en = 1'b1;
							u2_ctl.op   = OP_SHIFT_OUT;
						end
					end
				end
				default: begin
					status_nxt = ST_OK;
				end
			endcase
		end
	end

	swmd_chain #(
		.DW (DATA_WIDTH),
		.N  (LD),
		.IW (LIW)
	) u_lower (
		.clk     (clk),
		.ctl     (l_ctl),
		.head    (l_head),
		.wr_idx  (l_widx),
		.wr_data (l_wdata),
		.head_q  (l_q0),
		.head_d  (l_d0)
	);

	swmd_chain #(
		.DW (DATA_WIDTH),
		.N  (UD),
		.IW (UIW)
	) u_upper_top (
		.clk     (clk),
		.ctl     (u1_ctl),
		.head    (u1_head),
		.wr_idx  (u1_widx),
		.wr_data (u1_wdata),
		.head_q  (),
		.head_d  (u1_d0)
	);

	swmd_chain #(
		.DW (DATA_WIDTH),
		.N  (UD),
		.IW (UIW)
	) u_upper_bot (
		.clk     (clk),
		.ctl     (u2_ctl),
		.head    (u2_head),
		.wr_idx  (u2_widx),
		.wr_data (u2_wdata),
		.head_q  (u2_q0),
		.head_d  ()
	);

	assign mid_word = l_d0;
	assign top_word = (count_nxt == CW'(1)) ? l_d0 : u1_d0;
	assign mid_ext  = EW'(mid_word);
	assign top_ext  = EW'(top_word);

	always_comb begin
		rsp_nxt.entry_count = COUNT_W'(count_nxt);
		rsp_nxt.status      = status_nxt;
		if (count_nxt == '0) begin
			rsp_nxt.top_value    = '0;
			rsp_nxt.middle_value = '0;
			rsp_nxt.is_empty     = 1'b1;
		end else begin
			rsp_nxt.top_value    = top_ext[FIELD_W-1:0];
			rsp_nxt.middle_value = mid_ext[FIELD_W-1:0];
			rsp_nxt.is_empty     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_nxt;
			if (acc) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_q <= rsp_nxt;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// File: hdl/swmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swmd_checker
// Port-level checks for the stack with middle delete.
// ----------------------------------------------------------------------------
module swmd_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input swmd_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input swmd_pkg::rsp_t rsp
);
	import swmd_pkg::*;

	// a stalled request keeps its payload until it is taken
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("stalled request changed");

	// every accepted request shows its result on the next cycle
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("accepted request produced no result");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled result changed");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.is_empty |->
			rsp.top_value == '0 && rsp.middle_value == '0)
		else $error("empty stack shows nonzero words");

	// an empty-side error leaves the stack empty, a full reject leaves it non-empty
	a_status_state: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |->
			(rsp.status != ST_EMPTY || rsp.is_empty) &&
			(rsp.status != ST_FULL || !rsp.is_empty))
		else $error("status disagrees with fill state");

endmodule

bind stack_with_middle_delete swmd_checker u_swmd_checker (.*);

// File: verif/stack_with_middle_delete_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_with_middle_delete_test
// Self-checking bench for the stack with middle delete. A queue-fed driver
// sends requests and a monitor checks every result against a queue-based
// model of the stack. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module stack_with_middle_delete_test;
	import swmd_pkg::*;

	localparam int STACK_DEPTH  = 64;
	localparam int TAIL_ITEMS   = 150;
	localparam int LIMIT_CYCLES = 400000;
	localparam int MODE_FILL    = 0;
	localparam int MODE_EMPTY   = 1;
	localparam int MODE_MIX     = 2;

	typedef struct {
		req_t r;
		bit   drain;	// hold this request until every result is back
	} pending_req_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req       = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	pending_req_t      pending_reqs[$];
	rsp_t              expected_rsp[$];
	logic signed [31:0] stack_words[$];

	int unsigned total_items = 0;
	int unsigned sent_cnt    = 0;
	int unsigned rcvd_cnt    = 0;
	int unsigned err_cnt     = 0;
	int unsigned cycle_cnt   = 0;
	int unsigned send_gap    = 0;
	int unsigned send_pct    = 0;
	int unsigned stall_left  = 0;
	int unsigned stall_pct   = 0;
	logic        stall_next;

	stack_with_middle_delete #(
		.DEPTH      (STACK_DEPTH),
		.DATA_WIDTH (32)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	function automatic int unsigned pick_pct();
		case ($urandom_range(0, 4))
			0, 1: return 0;
			2: return 10;
			3: return 30;
			default: return 60;
		endcase
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	task automatic add_req(input req_kind_t kind, input logic [31:0] value, input bit drain);
		pending_req_t p;
		p.r.req_type   = kind;
		p.r.push_value = value;
		p.drain        = drain;
		pending_reqs.push_back(p);
	endtask

	// Random part: segments biased toward filling, emptying or a mix so the
	// fill level sweeps from empty to full and back.
	task automatic add_random(input int unsigned n_items);
		int unsigned done;
		int unsigned seg;
		int unsigned mode;
		int unsigned roll;
		int unsigned q_th;
		int unsigned push_th;
		int unsigned pop_th;
		req_kind_t   kind;
		bit          drain;
		done = 0;
		mode = MODE_FILL;
		seg  = 150;
		while (done < n_items) begin
			case (mode)
				MODE_FILL: begin
					q_th = 5; push_th = 80; pop_th = 90;
				end
				MODE_EMPTY: begin
					q_th = 5; push_th = 20; pop_th = 60;
				end
				default: begin
					q_th = 10; push_th = 55; pop_th = 75;
				end
			endcase
			for (int unsigned k = 0; k < seg && done < n_items; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < q_th)
					kind = REQ_QUERY;
				else if (roll < push_th)
					kind = REQ_PUSH;
				else if (roll < pop_th)
					kind = REQ_POP;
				else
					kind = REQ_DELMID;
				drain = (done == 0) || (done == n_items / 2);
				add_req(kind, pick_word(), drain);
				done++;
			end
			mode = $urandom_range(0, 2);
			seg  = $urandom_range(20, 120);
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_cnt++;
	endtask

	// Applies one accepted request to the stack copy and queues its result.
	task automatic predict_stack(input req_t r);
		rsp_t e;
		int   n;
		e        = '0;
		e.status = ST_OK;
		case (r.req_type)
			REQ_PUSH: begin
				if (stack_words.size() >= STACK_DEPTH)
					e.status = ST_FULL;
				else
					stack_words.push_back(r.push_value);
			end
			REQ_POP: begin
				if (stack_words.size() == 0)
					e.status = ST_EMPTY;
				else
					void'(stack_words.pop_back());
			end
			REQ_DELMID: begin
				if (stack_words.size() == 0)
					e.status = ST_EMPTY;
				else
					stack_words.delete((stack_words.size() - 1) / 2);
			end
			default: ;
		endcase
		n = stack_words.size();
		if (n == 0) begin
			e.is_empty = 1'b1;
		end else begin
			e.top_value    = stack_words[n - 1];
			e.middle_value = stack_words[(n - 1) / 2];
		end
		e.entry_count = n[COUNT_W-1:0];
		expected_rsp.push_back(e);
	endtask

	task automatic check_rsp(input rsp_t got);
		rsp_t e;
		if (expected_rsp.size() == 0) begin
			report_mismatch("result with no request outstanding");
			return;
		end
		e = expected_rsp.pop_front();
		if (got.top_value !== e.top_value)
			report_mismatch($sformatf("result %0d top_value %0d, want %0d",
				rcvd_cnt, got.top_value, e.top_value));
		if (got.middle_value !== e.middle_value)
			report_mismatch($sformatf("result %0d middle_value %0d, want %0d",
				rcvd_cnt, got.middle_value, e.middle_value));
		if (got.entry_count !== e.entry_count)
			report_mismatch($sformatf("result %0d entry_count %0d, want %0d",
				rcvd_cnt, got.entry_count, e.entry_count));
		if (got.is_empty !== e.is_empty)
			report_mismatch($sformatf("result %0d is_empty %0b, want %0b",
				rcvd_cnt, got.is_empty, e.is_empty));
		if (got.status !== e.status)
			report_mismatch($sformatf("result %0d status %0d, want %0d",
				rcvd_cnt, got.status, e.status));
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req       <= '0;
		end else if (!(req_valid && req_stall)) begin
			if (req_valid) begin
				predict_stack(req);
				sent_cnt++;
			end
			if ($urandom_range(0, 63) == 0)
				send_pct = pick_pct();
			if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() != 0 &&
					!(pending_reqs[0].drain && expected_rsp.size() != 0)) begin
				if (sent_cnt + TAIL_ITEMS < total_items &&
						$urandom_range(0, 99) < send_pct) begin
					send_gap = $urandom_range(1, 17) - 1;
					req_valid <= 1'b0;
				end else begin
					req_valid <= 1'b1;
					req       <= pending_reqs[0].r;
					void'(pending_reqs.pop_front());
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				check_rsp(rsp);
				rcvd_cnt++;
			end
			if ($urandom_range(0, 63) == 0)
				stall_pct = pick_pct();
			if (stall_left > 0) begin
				stall_left--;
				stall_next = 1'b1;
			end else if (rcvd_cnt + TAIL_ITEMS < total_items &&
					$urandom_range(0, 99) < stall_pct) begin
				stall_left = $urandom_range(1, 17) - 1;
				stall_next = 1'b1;
			end else begin
				stall_next = 1'b0;
			end
			rsp_stall <= stall_next;
		end
	end

	initial begin
		while (cycle_cnt < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("stack_with_middle_delete: mismatch");
		$finish;
	end

	initial begin
		// empty-stack cases, extreme words, delete at odd and even counts
		add_req(REQ_QUERY,  32'h1234_5678, 1'b0);
		add_req(REQ_POP,    32'hffff_ffff, 1'b0);
		add_req(REQ_DELMID, 32'h8000_0000, 1'b0);
		add_req(REQ_PUSH,   32'h8000_0000, 1'b0);
		add_req(REQ_PUSH,   32'h7fff_ffff, 1'b0);
		add_req(REQ_QUERY,  32'h0000_0000, 1'b0);
		add_req(REQ_PUSH,   32'h0000_0000, 1'b0);
		add_req(REQ_PUSH,   32'hffff_ffff, 1'b0);
		add_req(REQ_PUSH,   32'h5a5a_5a5a, 1'b0);
		add_req(REQ_DELMID, 32'h0000_0000, 1'b0);
		add_req(REQ_DELMID, 32'hffff_ffff, 1'b0);
		add_req(REQ_POP,    32'h0000_0000, 1'b0);
		add_req(REQ_QUERY,  32'hffff_ffff, 1'b0);
		add_req(REQ_PUSH,   32'ha5a5_a5a5, 1'b0);
		add_req(REQ_DELMID, 32'h0000_0000, 1'b0);
		add_req(REQ_DELMID, 32'h0000_0000, 1'b0);
		add_req(REQ_DELMID, 32'h0000_0000, 1'b0);
		add_req(REQ_DELMID, 32'h0000_0000, 1'b0);
		add_req(REQ_POP,    32'h0000_0000, 1'b0);
		add_req(REQ_PUSH,   32'h0000_0001, 1'b0);
		add_req(REQ_QUERY,  32'h0000_0000, 1'b0);
		add_random(1930);
		total_items = pending_reqs.size();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_rsp.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (err_cnt == 0 && expected_rsp.size() == 0)
			$display("stack_with_middle_delete: match");
		else
			$display("stack_with_middle_delete: mismatch");
		$finish;
	end

endmodule
